/* design/nhd_pkg.sv */
// Shared types and constants for the NRZI HDLC bit deframer.
`timescale 1ns / 1ps
`default_nettype none

package nhd_pkg;

    // Drift history depth and derived widths.
    localparam int DRIFT_DEPTH = 6;
    localparam int SLOT_W      = (DRIFT_DEPTH > 1) ? $clog2(DRIFT_DEPTH) : 1;
    localparam int DRIFT_W     = 5;
    localparam int SUM_W       = $clog2(DRIFT_DEPTH * 16 + 1) + 1;

    // Restoring divider: one quotient bit per step over the 9-bit dividend.
    localparam int DIV_W       = 9;
    localparam int DIV_STEPS   = DIV_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [5:0] SPB_MIN   = 6'd4;
    localparam logic [5:0] SPB_MAX   = 6'd32;

    // Register reset values.
    localparam logic [5:0] SPB_RST  = 6'd11;
    localparam logic [4:0] THR_RST  = 5'd3;
    localparam logic [7:0] MINF_RST = 8'd10;
    localparam logic [7:0] MAXF_RST = 8'd200;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_SAMPLES_PER_BIT = 2'd0,
        CFG_DRIFT_THRESHOLD = 2'd1,
        CFG_MIN_FRAME_BYTES = 2'd2,
        CFG_MAX_FRAME_BYTES = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_START = 2'd1,
        KIND_END   = 2'd2,
        KIND_ABORT = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_UPDATE,
        ST_SCAN,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic start;
        logic div_step;
        logic update;
        logic scan_step;
        logic drain_step;
    } t_dp_cmd;

    typedef struct packed {
        logic div_last;
        logic scan_more;
        logic res_none;
        logic drain_last;
    } t_dp_stat;

endpackage

`default_nettype wire

/* design/nhd_ctrl.sv */
// Sequencing state machine for the NRZI HDLC bit deframer.
`timescale 1ns / 1ps
`default_nettype none

module nhd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_out_free,
    input  nhd_pkg::t_dp_stat i_stat,
    output nhd_pkg::t_dp_cmd  o_cmd
);
    import nhd_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_DIV;
            end
            ST_DIV: begin
                if (i_stat.div_last) n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (!i_stat.scan_more) begin
                    n_state = i_stat.res_none ? ST_IDLE : ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (i_out_free && i_stat.drain_last) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.start = i_in_valid;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
            end
            ST_SCAN: begin
                o_cmd.scan_step = i_stat.scan_more;
            end
            ST_DRAIN: begin
                o_cmd.drain_step = i_out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* design/nhd_datapath.sv */
// Datapath: config registers, divider, drift history, bit queue and result buffer.
`timescale 1ns / 1ps
`default_nettype none

module nhd_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [1:0]        i_cfg_index,
    input  logic [7:0]        i_cfg_data,
    input  logic [7:0]        i_samples,
    input  nhd_pkg::t_dp_cmd  i_cmd,
    output nhd_pkg::t_dp_stat o_stat,
    output nhd_pkg::t_kind    o_res_kind,
    output logic [7:0]        o_res_byte,
    output logic              o_res_last
);
    import nhd_pkg::*;

    // Configuration
    logic [5:0] r_spb;
    logic [4:0] r_thr;
    logic [7:0] r_min_bytes;
    logic [7:0] r_max_bytes;

    // Divider
    logic [DIV_W-1:0]     r_quo;
    logic [5:0]           r_rem;
    logic [DIV_CNT_W-1:0] r_div_cnt;

    // Link state
    logic [15:0] r_queue,       n_queue;
    logic [4:0]  r_queued,      n_queued;
    logic        r_in_frame,    n_in_frame;
    logic [7:0]  r_frame_bytes, n_frame_bytes;

    // Drift tracking
    logic signed [DRIFT_W-1:0] r_hist [DRIFT_DEPTH];
    logic signed [SUM_W-1:0]   r_sum;
    logic [SLOT_W-1:0]         r_slot;

    // Results of the current item
    t_kind      r_res_kind [2];
    logic [7:0] r_res_byte [2];
    logic [1:0] r_res_cnt;
    logic       r_drain_idx;

    logic [5:0]                spb_c;
    logic [4:0]                half;
    logic signed [SUM_W-1:0]   thr_pos;
    logic signed [SUM_W-1:0]   thr_neg;
    logic [7:0]                s_adj;
    logic [DIV_W-1:0]          t_val;
    logic [6:0]                trial;
    logic                      trial_ge;
    logic signed [6:0]         err_w;
    logic signed [DRIFT_W-1:0] err;
    logic [SLOT_W-1:0]         slot_n;
    logic signed [DRIFT_W-1:0] hist_old;
    logic [4:0]                ones_mask;
    logic [4:0]                add_bits;
    logic [7:0]                byte_lo;
    logic                      put_en;
    t_kind                     put_kind;
    logic [7:0]                put_byte;

    // Clamp the bit rate and form the rounding offset.
    always_comb begin
        if (r_spb < SPB_MIN) begin
            spb_c = SPB_MIN;
        end else if (r_spb > SPB_MAX) begin
            spb_c = SPB_MAX;
        end else begin
            spb_c = r_spb;
        end
        half    = spb_c[5:1];
        thr_pos = $signed(SUM_W'({1'b0, r_thr}));
        thr_neg = -thr_pos;
    end

    // Nudge the count against accumulated drift, then add half a bit.
    always_comb begin
        s_adj = i_samples;
        if (r_sum >= thr_pos) begin
            s_adj = i_samples - 8'd1;
        end else if (r_sum <= thr_neg) begin
            s_adj = i_samples + 8'd1;
        end
        t_val = DIV_W'({1'b0, s_adj}) + DIV_W'(half);
    end

    assign trial    = {r_rem, r_quo[DIV_W-1]};
    assign trial_ge = (trial >= {1'b0, spb_c});

    // Drift of this change and the history slot it lands in.
    always_comb begin
        err_w    = $signed({1'b0, r_rem}) - $signed({2'b00, half});
        err      = err_w[DRIFT_W-1:0];
        slot_n   = (r_slot == SLOT_W'(DRIFT_DEPTH - 1)) ? '0 : r_slot + SLOT_W'(1);
        hist_old = r_hist[slot_n];
    end

    // Ones queued for a run of two to six bit times.
    always_comb begin
        case (r_quo)
            9'd2:    begin ones_mask = 5'b00001; add_bits = 5'd2; end
            9'd3:    begin ones_mask = 5'b00011; add_bits = 5'd3; end
            9'd4:    begin ones_mask = 5'b00111; add_bits = 5'd4; end
            9'd5:    begin ones_mask = 5'b01111; add_bits = 5'd5; end
            9'd6:    begin ones_mask = 5'b11111; add_bits = 5'd5; end
            default: begin ones_mask = 5'b00000; add_bits = 5'd0; end
        endcase
    end

    assign byte_lo = r_queue[7:0];

    // Bit queue update and byte extraction.
    always_comb begin
        n_queue       = r_queue;
        n_queued      = r_queued;
        n_in_frame    = r_in_frame;
        n_frame_bytes = r_frame_bytes;
        put_en        = 1'b0;
        put_kind      = KIND_DATA;
        put_byte      = 8'h00;
        if (i_cmd.update) begin
            case (r_quo)
                9'd1: begin
                    n_queued = r_queued + 5'd1;
                end
                9'd2, 9'd3, 9'd4, 9'd5, 9'd6: begin
                    n_queue  = r_queue | (16'(ones_mask) << r_queued[3:0]);
                    n_queued = r_queued + add_bits;
                end
                9'd7: begin
                    if (r_queued >= 5'd4) begin
                        n_queue  = {FLAG_BYTE, r_queue[7:0]};
                        n_queued = 5'd16;
                    end else begin
                        n_queue  = {8'h00, FLAG_BYTE};
                        n_queued = 5'd8;
                    end
                end
                default: begin
                    n_queue       = '0;
                    n_queued      = '0;
                    n_in_frame    = 1'b0;
                    n_frame_bytes = '0;
                    put_en        = r_in_frame;
                    put_kind      = KIND_ABORT;
                end
            endcase
        end else if (i_cmd.scan_step) begin
            if (byte_lo == FLAG_BYTE) begin
                if (!r_in_frame) begin
                    n_in_frame = 1'b1;
                    put_en     = 1'b1;
                    put_kind   = KIND_START;
                end else if (r_frame_bytes >= r_min_bytes) begin
                    put_en        = 1'b1;
                    put_kind      = KIND_END;
                    n_frame_bytes = '0;
                end
                n_queue  = r_queue >> 8;
                n_queued = r_queued - 5'd8;
            end else if (r_in_frame) begin
                if (r_frame_bytes >= r_max_bytes) begin
                    // Overrun: drop the frame and stop taking bytes.
                    n_queue       = '0;
                    n_queued      = '0;
                    n_in_frame    = 1'b0;
                    n_frame_bytes = '0;
                    put_en        = 1'b1;
                    put_kind      = KIND_ABORT;
                end else begin
                    put_en        = 1'b1;
                    put_kind      = KIND_DATA;
                    put_byte      = byte_lo;
                    n_frame_bytes = r_frame_bytes + 8'd1;
                    n_queue       = r_queue >> 8;
                    n_queued      = r_queued - 5'd8;
                end
            end else begin
                // Hunt for a flag one bit at a time.
                n_queue  = r_queue >> 1;
                n_queued = r_queued - 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spb         <= SPB_RST;
            r_thr         <= THR_RST;
            r_min_bytes   <= MINF_RST;
            r_max_bytes   <= MAXF_RST;
            r_queue       <= '0;
            r_queued      <= '0;
            r_in_frame    <= 1'b0;
            r_frame_bytes <= '0;
            r_sum         <= '0;
            r_slot        <= '0;
            r_res_cnt     <= '0;
            r_drain_idx   <= 1'b0;
            r_div_cnt     <= '0;
            for (int i = 0; i < DRIFT_DEPTH; i++) begin
                r_hist[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_SAMPLES_PER_BIT: r_spb       <= i_cfg_data[5:0];
                    CFG_DRIFT_THRESHOLD: r_thr       <= i_cfg_data[4:0];
                    CFG_MIN_FRAME_BYTES: r_min_bytes <= i_cfg_data;
                    CFG_MAX_FRAME_BYTES: r_max_bytes <= i_cfg_data;
                    default: ;
                endcase
            end

            r_queue       <= n_queue;
            r_queued      <= n_queued;
            r_in_frame    <= n_in_frame;
            r_frame_bytes <= n_frame_bytes;

            if (i_cmd.start) begin
                r_div_cnt   <= '0;
                r_res_cnt   <= '0;
                r_drain_idx <= 1'b0;
            end else begin
                if (i_cmd.div_step) begin
                    r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
                end
                if (put_en && (r_res_cnt != 2'd2)) begin
                    r_res_cnt <= r_res_cnt + 2'd1;
                end
                if (i_cmd.drain_step) begin
                    r_drain_idx <= r_drain_idx + 1'b1;
                end
            end

            if (i_cmd.update) begin
                r_slot         <= slot_n;
                r_hist[slot_n] <= err;
                r_sum          <= r_sum - SUM_W'(hist_old) + SUM_W'(err);
            end
        end
    end

    // Divider and result payload: no reset needed.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_quo <= t_val;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[DIV_W-2:0], trial_ge};
            r_rem <= trial_ge ? 6'(trial - {1'b0, spb_c}) : trial[5:0];
        end
        if (put_en && (r_res_cnt != 2'd2)) begin
            r_res_kind[r_res_cnt[0]] <= put_kind;
            r_res_byte[r_res_cnt[0]] <= put_byte;
        end
    end

    always_comb begin
        o_stat.div_last   = (r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1));
        o_stat.scan_more  = (r_queued >= 5'd8);
        o_stat.res_none   = (r_res_cnt == 2'd0);
        o_stat.drain_last = ({1'b0, r_drain_idx} == (r_res_cnt - 2'd1));
        o_res_kind        = r_res_kind[r_drain_idx];
        o_res_byte        = r_res_byte[r_drain_idx];
        o_res_last        = o_stat.drain_last;
    end

endmodule

`default_nettype wire

/* design/nrzi_hdlc_bit_deframer_unit.sv */
// Top level of the NRZI HDLC bit deframer: controller, datapath and output register.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Signals                                     Direction
// input     i_in_valid / o_in_ready, i_samples          into block
// result    o_out_valid / i_out_ready, o_kind,          out of block
//           o_data_byte, o_last
// config    i_cfg_valid / o_cfg_ready, i_cfg_index,     into block
//           i_cfg_data
//
// An item passes through an accept step, the restoring divider (one quotient
// bit per step), an update of the drift history and bit queue, a scan that
// takes one byte or hunted bit from the queue per step, and a drain step per
// result, which waits while the result side stalls.
// Reset (synchronous, active low) clears the link state, drift history and
// registers to their defaults. A stalled result holds in the output register;
// the next item is taken once the last result of this one is loaded there.

module nrzi_hdlc_bit_deframer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_samples,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_kind,
    output logic [7:0] o_data_byte,
    output logic       o_last,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);
    import nhd_pkg::*;

    t_dp_cmd    cmd;
    t_dp_stat   stat;
    t_kind      res_kind;
    logic [7:0] res_byte;
    logic       res_last;
    logic       out_free;

    logic       r_out_valid;
    t_kind      r_out_kind;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    // Registers take a write in any cycle; the user must write only while idle, the block does not enforce it.
    assign o_cfg_ready = 1'b1;

    // The output register can take a new item when empty or being emptied.
    assign out_free = !r_out_valid || i_out_ready;

    nhd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    nhd_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_samples   (i_samples),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_res_kind  (res_kind),
        .o_res_byte  (res_byte),
        .o_res_last  (res_last)
    );

    // Hold the valid flag: set on load, drop when the item is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.drain_step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Load the payload from the result buffer, one item per drain step.
    always_ff @(posedge i_clk) begin
        if (cmd.drain_step) begin
            r_out_kind <= res_kind;
            r_out_byte <= res_byte;
            r_out_last <= res_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_out_kind;
    assign o_data_byte = r_out_byte;
    assign o_last      = r_out_last;

endmodule

`default_nettype wire
